[rtl/csa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csa_pkg
// Shared constants and types for the contiguous segment allocator.
// ---------------------------------------------------------------------------
package csa_pkg;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STR_W  = 2;
  localparam int unsigned STAT_W = 3;

  localparam logic [SIZE_W-1:0] MEM_MAX = SIZE_W'(1) << ADDR_W;

  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  localparam logic [STR_W-1:0] FIT_F    = 2'd0;
  localparam logic [STR_W-1:0] FIT_B    = 2'd1;
  localparam logic [STR_W-1:0] FIT_W    = 2'd2;
  localparam logic [STR_W-1:0] FIT_NONE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADSIZE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch a new item, restart the walk
    logic step;    // process one table position
    logic commit;  // apply the table edit, result is taken
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;    // current position is the last one of the walk
  } dp_stat_t;

endpackage

[rtl/contiguous_segment_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// contiguous_segment_allocator
// Segment table allocator with first/best/worst fit, release and compaction.
// ---------------------------------------------------------------------------
// The walk visits one table position per cycle, covering every segment in the
// table, and every command also visits the tail hole. The result is registered
// on commit, which waits until the output register is free. A new item is taken
// only after that commit, while the previous result may still wait on the output.
// Reset: table empty, memory_size = 2^20, no result pending.
module contiguous_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // process_id[7:0], request_size[28:8],
                                     // strategy[30:29], zero[31]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status[2:0], alloc_start[22:3],
                                     // alloc_end[42:23], zero[47:43]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [20:0] cfg_data_i
);

  csa_pkg::dp_cmd_t  cmd;
  csa_pkg::dp_stat_t stat;

  logic [csa_pkg::SIZE_W-1:0] mem_q;
  logic [csa_pkg::STAT_W-1:0] status;
  logic [csa_pkg::ADDR_W-1:0] a_start, a_end;
  logic                       out_valid_q, out_free;
  logic [42:0]                out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= csa_pkg::MEM_MAX;
    end else if (cfg_valid_i) begin
      if (cfg_data_i == '0)                   mem_q <= csa_pkg::SIZE_W'(1);
      else if (cfg_data_i > csa_pkg::MEM_MAX) mem_q <= csa_pkg::MEM_MAX;
      else                                    mem_q <= cfg_data_i;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  csa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  csa_dp #(
    .MaxSeg (MAX_SEGMENTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .command_i      (s_axis_tuser),
    .process_id_i   (s_axis_tdata[7:0]),
    .request_size_i (s_axis_tdata[28:8]),
    .strategy_i     (s_axis_tdata[30:29]),
    .mem_size_i     (mem_q),
    .status_o       (status),
    .alloc_start_o  (a_start),
    .alloc_end_o    (a_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.commit) out_q <= {a_end, a_start, status};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q};

endmodule

[rtl/csa_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csa_ctrl
// Sequencer: accept an item, walk the table, then hand off the result.
// ---------------------------------------------------------------------------
module csa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  input  csa_pkg::dp_stat_t stat_i,
  output csa_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WORK   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WORK;
        end
      end
      S_WORK: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

[rtl/csa_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csa_dp
// Segment table, hole walk, fit selection, insert/remove shift and compaction.
// ---------------------------------------------------------------------------
module csa_dp #(
  parameter int unsigned MaxSeg = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csa_pkg::dp_cmd_t              cmd_i,
  output csa_pkg::dp_stat_t             stat_o,
  input  logic [csa_pkg::CMD_W-1:0]     command_i,
  input  logic [csa_pkg::ID_W-1:0]      process_id_i,
  input  logic [csa_pkg::SIZE_W-1:0]    request_size_i,
  input  logic [csa_pkg::STR_W-1:0]     strategy_i,
  input  logic [csa_pkg::SIZE_W-1:0]    mem_size_i,
  output logic [csa_pkg::STAT_W-1:0]    status_o,
  output logic [csa_pkg::ADDR_W-1:0]    alloc_start_o,
  output logic [csa_pkg::ADDR_W-1:0]    alloc_end_o
);

  localparam int unsigned IW = (MaxSeg > 1) ? $clog2(MaxSeg) : 1;
  localparam int unsigned CW = $clog2(MaxSeg + 1);
  localparam int unsigned AW = csa_pkg::ADDR_W;
  localparam int unsigned SW = csa_pkg::SIZE_W;

  logic [csa_pkg::ID_W-1:0] own_q [MaxSeg];
  logic [AW-1:0]            st_q  [MaxSeg];
  logic [AW-1:0]            en_q  [MaxSeg];
  logic [csa_pkg::ID_W-1:0] own_up [MaxSeg], own_dn [MaxSeg];
  logic [AW-1:0]            st_up  [MaxSeg], st_dn  [MaxSeg];
  logic [AW-1:0]            en_up  [MaxSeg], en_dn  [MaxSeg];

  logic [CW-1:0]                 cnt_q, idx_q, pick_q;
  logic [IW-1:0]                 hit_q;
  logic [csa_pkg::CMD_W-1:0]     cmd_q;
  logic [csa_pkg::ID_W-1:0]      id_q;
  logic [SW-1:0]                 size_q, pick_len_q, pick_base_q, next_q;
  logic [csa_pkg::STR_W-1:0]     strat_q;
  logic [AW-1:0]                 prev_end_q;
  logic                          dup_q, found_q;

  logic [IW-1:0] cur;
  logic          in_tab, fits, take, req_ok, rel_ok;
  logic [SW-1:0] base, lim, len, span, pack_end;
  logic [SW-1:0] end_full;

  for (genvar k = 0; k < MaxSeg; k++) begin : g_nb
    if (k > 0) begin : g_up
      assign own_up[k] = own_q[k-1];
      assign st_up[k]  = st_q[k-1];
      assign en_up[k]  = en_q[k-1];
    end else begin : g_up0
      assign own_up[k] = own_q[k];
      assign st_up[k]  = st_q[k];
      assign en_up[k]  = en_q[k];
    end
    if (k + 1 < MaxSeg) begin : g_dn
      assign own_dn[k] = own_q[k+1];
      assign st_dn[k]  = st_q[k+1];
      assign en_dn[k]  = en_q[k+1];
    end else begin : g_dn0
      assign own_dn[k] = own_q[k];
      assign st_dn[k]  = st_q[k];
      assign en_dn[k]  = en_q[k];
    end
  end

  assign cur    = idx_q[IW-1:0];
  assign in_tab = idx_q < cnt_q;
  assign base   = (idx_q == '0) ? '0 : SW'(prev_end_q) + SW'(1);
  assign lim    = in_tab ? SW'(st_q[cur]) : mem_size_i;
  assign len    = (lim > base) ? lim - base : '0;
  assign fits   = (len >= size_q) && (strat_q <= csa_pkg::FIT_W);
  // first fit keeps the earliest hole; best/worst replace only on strict gain
  assign take   = fits && (!found_q ||
                  ((strat_q == csa_pkg::FIT_B) && (len < pick_len_q)) ||
                  ((strat_q == csa_pkg::FIT_W) && (len > pick_len_q)));
  assign span     = in_tab ? SW'(en_q[cur] - st_q[cur]) : '0;
  assign pack_end = next_q + span;
  assign end_full = pick_base_q + size_q - SW'(1);

  assign stat_o.last = (idx_q == cnt_q);

  assign req_ok = !dup_q && (size_q != '0) && (cnt_q != CW'(MaxSeg)) && found_q;
  assign rel_ok = (cnt_q != '0) && dup_q;

  always_comb begin
    status_o      = csa_pkg::ST_OK;
    alloc_start_o = '0;
    alloc_end_o   = '0;
    case (cmd_q)
      csa_pkg::CMD_REQUEST: begin
        if (dup_q)                        status_o = csa_pkg::ST_DUP;
        else if (size_q == '0)            status_o = csa_pkg::ST_BADSIZE;
        else if (cnt_q == CW'(MaxSeg))    status_o = csa_pkg::ST_FULL;
        else if (!found_q)                status_o = csa_pkg::ST_NOFIT;
        else begin
          alloc_start_o = pick_base_q[AW-1:0];
          alloc_end_o   = end_full[AW-1:0];
        end
      end
      csa_pkg::CMD_RELEASE: begin
        if (cnt_q == '0)  status_o = csa_pkg::ST_EMPTY;
        else if (!dup_q)  status_o = csa_pkg::ST_NOTFOUND;
      end
      csa_pkg::CMD_COMPACT: begin
        if (cnt_q == '0) status_o = csa_pkg::ST_EMPTY;
      end
      default: status_o = csa_pkg::ST_OK;
    endcase
  end

  // walk state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q       <= command_i;
      id_q        <= process_id_i;
      size_q      <= request_size_i;
      strat_q     <= strategy_i;
      idx_q       <= '0;
      prev_end_q  <= '0;
      dup_q       <= 1'b0;
      found_q     <= 1'b0;
      hit_q       <= '0;
      pick_q      <= '0;
      pick_len_q  <= '0;
      pick_base_q <= '0;
      next_q      <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + CW'(1);
      if (in_tab) begin
        prev_end_q <= en_q[cur];
        if ((own_q[cur] == id_q) && !dup_q) begin
          dup_q <= 1'b1;
          hit_q <= cur;
        end
        next_q <= pack_end + SW'(1);
      end
      if ((cmd_q == csa_pkg::CMD_REQUEST) && take) begin
        found_q     <= 1'b1;
        pick_q      <= idx_q;
        pick_len_q  <= len;
        pick_base_q <= base;
      end
    end
  end

  // segment table
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxSeg; k++) begin
      if (cmd_i.step && (cmd_q == csa_pkg::CMD_COMPACT) && in_tab &&
          (cur == IW'(k))) begin
        st_q[k] <= next_q[AW-1:0];
        en_q[k] <= pack_end[AW-1:0];
      end else if (cmd_i.commit && (cmd_q == csa_pkg::CMD_REQUEST) && req_ok) begin
        if (CW'(k) == pick_q) begin
          own_q[k] <= id_q;
          st_q[k]  <= pick_base_q[AW-1:0];
          en_q[k]  <= end_full[AW-1:0];
        end else if ((CW'(k) > pick_q) && (CW'(k) <= cnt_q)) begin
          own_q[k] <= own_up[k];
          st_q[k]  <= st_up[k];
          en_q[k]  <= en_up[k];
        end
      end else if (cmd_i.commit && (cmd_q == csa_pkg::CMD_RELEASE) && rel_ok) begin
        if ((CW'(k) >= CW'(hit_q)) && ((CW'(k) + CW'(1)) < cnt_q)) begin
          own_q[k] <= own_dn[k];
          st_q[k]  <= st_dn[k];
          en_q[k]  <= en_dn[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      if ((cmd_q == csa_pkg::CMD_REQUEST) && req_ok)      cnt_q <= cnt_q + CW'(1);
      else if ((cmd_q == csa_pkg::CMD_RELEASE) && rel_ok) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule
